[sv/extended_hamming_8_4_byte_codec_unit_macros.svh]
// Assertion macros of the codec top-level RTL file.
`ifndef EXTENDED_HAMMING_8_4_BYTE_CODEC_UNIT_MACROS_SVH
`define EXTENDED_HAMMING_8_4_BYTE_CODEC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define EHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define EHC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define EHC_ASSERT(lbl, prop, msg)
`define EHC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[sv/ehc_pkg.sv]
// Types, codes and helper functions of the extended Hamming byte codec.
`default_nettype none

package ehc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NUM_BYTES = 4;
  localparam int unsigned CNT_W = 32;

  typedef logic [NUM_BYTES-1:0][BYTE_W-1:0] byte4_t;

  typedef enum logic [1:0] {
    ST_CLEAN         = 2'd0,
    ST_CORRECTED     = 2'd1,
    ST_UNCORRECTABLE = 2'd2
  } status_t;

  typedef logic [3:0] syndrome_t;

  localparam syndrome_t SYN_NONE = 4'h0;
  localparam syndrome_t SYN_C0   = 4'h8;
  localparam syndrome_t SYN_C1   = 4'h4;
  localparam syndrome_t SYN_C2   = 4'h2;
  localparam syndrome_t SYN_C3   = 4'h1;
  localparam syndrome_t SYN_D0   = 4'hb;
  localparam syndrome_t SYN_D1   = 4'hd;
  localparam syndrome_t SYN_D2   = 4'he;
  localparam syndrome_t SYN_D3   = 4'h7;

  typedef struct packed {
    byte4_t  data;
    byte4_t  check;
    status_t status;
  } codec_res_t;

  function automatic byte4_t make_checks(input byte4_t d);
    byte4_t c;
    c[0] = d[0] ^ d[1] ^ d[2];
    c[1] = d[1] ^ d[2] ^ d[3];
    c[2] = d[0] ^ d[2] ^ d[3];
    c[3] = d[0] ^ d[1] ^ d[3];
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/ehc_codec_logic.sv]
// Check byte generation, syndrome decode and single byte repair.
`default_nettype none

module ehc_codec_logic (
  input  logic               decode_mode,
  input  ehc_pkg::byte4_t    data_in,
  input  ehc_pkg::byte4_t    check_in,
  output ehc_pkg::codec_res_t res
);
  import ehc_pkg::*;

  byte4_t    calc;
  syndrome_t syn;

  assign calc   = make_checks(data_in);
  assign syn[3] = |(calc[0] ^ check_in[0]);
  assign syn[2] = |(calc[1] ^ check_in[1]);
  assign syn[1] = |(calc[2] ^ check_in[2]);
  assign syn[0] = |(calc[3] ^ check_in[3]);

  always_comb begin
    res.data   = data_in;
    res.check  = check_in;
    res.status = ST_CORRECTED;
    if (!decode_mode) begin
      res.check  = calc;
      res.status = ST_CLEAN;
    end else begin
      case (syn)
        SYN_NONE: res.status = ST_CLEAN;
        SYN_C0:   res.check[0] = calc[0];
        SYN_C1:   res.check[1] = calc[1];
        SYN_C2:   res.check[2] = calc[2];
        SYN_C3:   res.check[3] = calc[3];
        SYN_D0:   res.data[0] = check_in[0] ^ check_in[2] ^ check_in[3];
        SYN_D1:   res.data[1] = check_in[0] ^ check_in[1] ^ check_in[3];
        SYN_D2:   res.data[2] = check_in[0] ^ check_in[1] ^ check_in[2];
        SYN_D3:   res.data[3] = check_in[1] ^ check_in[2] ^ check_in[3];
        default:  res.status = ST_UNCORRECTABLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/ehc_err_counters.sv]
// Wrapping counters of corrected and uncorrectable groups.
`default_nettype none

module ehc_err_counters (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      upd,
  input  ehc_pkg::status_t          status,
  output logic [ehc_pkg::CNT_W-1:0] soft_cnt,
  output logic [ehc_pkg::CNT_W-1:0] hard_cnt
);
  import ehc_pkg::*;

  logic [CNT_W-1:0] soft_cnt_r, soft_cnt_nxt;
  logic [CNT_W-1:0] hard_cnt_r, hard_cnt_nxt;

  always_comb begin
    soft_cnt_nxt = soft_cnt_r;
    hard_cnt_nxt = hard_cnt_r;
    if (upd && status == ST_CORRECTED) begin
      soft_cnt_nxt = soft_cnt_r + CNT_W'(1);
    end
    if (upd && status == ST_UNCORRECTABLE) begin
      hard_cnt_nxt = hard_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_cnt_r <= '0;
      hard_cnt_r <= '0;
    end else begin
      soft_cnt_r <= soft_cnt_nxt;
      hard_cnt_r <= hard_cnt_nxt;
    end
  end

  assign soft_cnt = soft_cnt_r;
  assign hard_cnt = hard_cnt_r;

endmodule

`default_nettype wire

[sv/extended_hamming_8_4_byte_codec_unit.sv]
// Top level of the extended Hamming (8,4) byte codec with valid/ready channels.
`default_nettype none

// The block takes one group of four data bytes and four check bytes per beat and
// sustains one beat per clock cycle while out_ready is high. A beat passes an
// input register, then the check and repair logic, then a result register.
// in_ready follows out_ready combinationally when both registers are full. The
// error totals on the result channel are the counts after that beat and wrap at
// 32 bits. Change cfg_wr_data only while no beat is in flight.

`include "extended_hamming_8_4_byte_codec_unit_macros.svh"

module extended_hamming_8_4_byte_codec_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_0,
  input  logic [7:0]                in_data_1,
  input  logic [7:0]                in_data_2,
  input  logic [7:0]                in_data_3,
  input  logic [7:0]                in_check_0,
  input  logic [7:0]                in_check_1,
  input  logic [7:0]                in_check_2,
  input  logic [7:0]                in_check_3,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_data_0,
  output logic [7:0]                out_data_1,
  output logic [7:0]                out_data_2,
  output logic [7:0]                out_data_3,
  output logic [7:0]                out_check_0,
  output logic [7:0]                out_check_1,
  output logic [7:0]                out_check_2,
  output logic [7:0]                out_check_3,
  output logic [1:0]                out_status,
  output logic [ehc_pkg::CNT_W-1:0] out_corrected_total,
  output logic [ehc_pkg::CNT_W-1:0] out_uncorrectable_total
);
  import ehc_pkg::*;

  logic       decode_mode_r;
  logic       s1_valid_r;
  byte4_t     s1_data_r;
  byte4_t     s1_check_r;
  logic       s2_valid_r;
  codec_res_t s2_res_r;
  codec_res_t res;
  logic       s1_load;
  logic       s2_load;

  assign s2_load  = s1_valid_r && (!s2_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        decode_mode_r <= cfg_wr_data;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (out_ready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r  <= {in_data_3, in_data_2, in_data_1, in_data_0};
      s1_check_r <= {in_check_3, in_check_2, in_check_1, in_check_0};
    end
    if (s2_load) begin
      s2_res_r <= res;
    end
  end

  ehc_codec_logic u_codec (
    .decode_mode (decode_mode_r),
    .data_in     (s1_data_r),
    .check_in    (s1_check_r),
    .res         (res)
  );

  ehc_err_counters u_counters (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (s2_load),
    .status   (res.status),
    .soft_cnt (out_corrected_total),
    .hard_cnt (out_uncorrectable_total)
  );

  assign out_valid   = s2_valid_r;
  assign out_data_0  = s2_res_r.data[0];
  assign out_data_1  = s2_res_r.data[1];
  assign out_data_2  = s2_res_r.data[2];
  assign out_data_3  = s2_res_r.data[3];
  assign out_check_0 = s2_res_r.check[0];
  assign out_check_1 = s2_res_r.check[1];
  assign out_check_2 = s2_res_r.check[2];
  assign out_check_3 = s2_res_r.check[3];
  assign out_status  = s2_res_r.status;

  `EHC_ASSERT_RST(a_reset_clears, !rst_n |=> (!out_valid && !s1_valid_r && out_corrected_total == '0 && out_uncorrectable_total == '0), "reset did not clear pipeline and totals")
  `EHC_ASSERT(a_encode_quiet, (s2_load && !decode_mode_r) |=> (out_status == ST_CLEAN && $stable(out_corrected_total) && $stable(out_uncorrectable_total)), "encode beat changed status or totals")
  `EHC_ASSERT(a_totals_only_on_load, !s2_load |=> ($stable(out_corrected_total) && $stable(out_uncorrectable_total)), "totals changed without a new result")
  `EHC_ASSERT(a_input_held, (s1_valid_r && !s2_load) |=> s1_valid_r, "input beat lost while result stage was full")

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench of the extended Hamming (8,4) byte codec with directed and random groups.
`timescale 1ns / 100ps

module tb;
  import ehc_pkg::*;

  localparam bit MODE_ENCODE = 1'b0;
  localparam bit MODE_DECODE = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    byte4_t      data;
    byte4_t      check;
    status_t     status;
    logic [31:0] fixed;
    logic [31:0] lost;
  } codec_beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        out_ready;
  byte4_t      drv_data;
  byte4_t      drv_check;
  wire         in_ready;
  wire         out_valid;
  wire [3:0][7:0] got_data;
  wire [3:0][7:0] got_check;
  wire [1:0]   got_status;
  wire [31:0]  got_fixed;
  wire [31:0]  got_lost;

  codec_beat_t expected_beats[$];
  codec_beat_t head_beat;
  bit          mode_q;
  logic [31:0] fixed_cnt;
  logic [31:0] lost_cnt;
  bit          failed;
  bit          idle_on;
  int          out_hold;
  int unsigned cycle_cnt;

  extended_hamming_8_4_byte_codec_unit u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_data_0               (drv_data[0]),
    .in_data_1               (drv_data[1]),
    .in_data_2               (drv_data[2]),
    .in_data_3               (drv_data[3]),
    .in_check_0              (drv_check[0]),
    .in_check_1              (drv_check[1]),
    .in_check_2              (drv_check[2]),
    .in_check_3              (drv_check[3]),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_data_0              (got_data[0]),
    .out_data_1              (got_data[1]),
    .out_data_2              (got_data[2]),
    .out_data_3              (got_data[3]),
    .out_check_0             (got_check[0]),
    .out_check_1             (got_check[1]),
    .out_check_2             (got_check[2]),
    .out_check_3             (got_check[3]),
    .out_status              (got_status),
    .out_corrected_total     (got_fixed),
    .out_uncorrectable_total (got_lost)
  );

  always #1 clk = ~clk;

  function automatic byte4_t calc_checks(input byte4_t d);
    byte4_t c;
    c[0] = d[0] ^ d[1] ^ d[2];
    c[1] = d[1] ^ d[2] ^ d[3];
    c[2] = d[0] ^ d[2] ^ d[3];
    c[3] = d[0] ^ d[1] ^ d[3];
    return c;
  endfunction

  function automatic codec_beat_t predict_codec(input byte4_t d, input byte4_t r);
    codec_beat_t e;
    byte4_t      t;
    syndrome_t   syn;
    t = calc_checks(d);
    e.data = d;
    e.check = r;
    e.status = ST_CLEAN;
    syn = SYN_NONE;
    if (mode_q == MODE_ENCODE) begin
      e.check = t;
    end else begin
      for (int k = 0; k < 4; k++) syn[3-k] = |(t[k] ^ r[k]);
      e.status = ST_CORRECTED;
      case (syn)
        SYN_NONE: e.status = ST_CLEAN;
        SYN_C0: e.check[0] = t[0];
        SYN_C1: e.check[1] = t[1];
        SYN_C2: e.check[2] = t[2];
        SYN_C3: e.check[3] = t[3];
        SYN_D0: e.data[0] = r[0] ^ r[2] ^ r[3];
        SYN_D1: e.data[1] = r[0] ^ r[1] ^ r[3];
        SYN_D2: e.data[2] = r[0] ^ r[1] ^ r[2];
        SYN_D3: e.data[3] = r[1] ^ r[2] ^ r[3];
        default: e.status = ST_UNCORRECTABLE;
      endcase
      if (e.status == ST_CORRECTED) fixed_cnt = fixed_cnt + 32'd1;
      else if (e.status == ST_UNCORRECTABLE) lost_cnt = lost_cnt + 32'd1;
    end
    e.fixed = fixed_cnt;
    e.lost = lost_cnt;
    return e;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        failed = 1'b1;
      end else begin
        head_beat = expected_beats.pop_front();
        for (int k = 0; k < 4; k++) begin
          compare_field($sformatf("data_%0d", k), 32'(head_beat.data[k]), 32'(got_data[k]));
          compare_field($sformatf("check_%0d", k), 32'(head_beat.check[k]),
                        32'(got_check[k]));
        end
        compare_field("status", 32'(head_beat.status), 32'(got_status));
        compare_field("corrected_total", head_beat.fixed, got_fixed);
        compare_field("uncorrectable_total", head_beat.lost, got_lost);
      end
      out_hold = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  always @(negedge clk) begin
    out_ready = (out_hold == 0);
    if (out_hold > 0) out_hold = out_hold - 1;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_group(input byte4_t d, input byte4_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    drv_data = d;
    drv_check = c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_beats.push_back(predict_codec(d, c));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input bit m);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    mode_q = m;
  endtask

  task automatic send_random_decode();
    byte4_t d;
    byte4_t c;
    int     kind;
    int     p;
    d = $urandom;
    c = calc_checks(d);
    kind = $urandom_range(0, 9);
    if (kind >= 2 && kind <= 3) begin
      p = $urandom_range(0, 3);
      c[p] = c[p] ^ 8'($urandom_range(1, 255));
    end else if (kind >= 4 && kind <= 5) begin
      p = $urandom_range(0, 3);
      d[p] = d[p] ^ 8'($urandom_range(1, 255));
    end else if (kind >= 6 && kind <= 7) begin
      repeat (2) begin
        p = $urandom_range(0, 7);
        if (p < 4) d[p] = d[p] ^ 8'($urandom_range(1, 255));
        else c[p-4] = c[p-4] ^ 8'($urandom_range(1, 255));
      end
    end else if (kind == 8) begin
      c = $urandom;
    end
    send_group(d, c);
  endtask

  task automatic test_encode_corners();
    set_mode(MODE_ENCODE);
    send_group(32'h0000_0000, 32'hffff_ffff);
    send_group(32'hffff_ffff, 32'h0000_0000);
    send_group(32'h55aa_55aa, 32'h1234_5678);
    send_group(32'h0102_0408, 32'h8040_2010);
    send_group(32'h1020_4080, $urandom);
  endtask

  task automatic test_decode_corners();
    byte4_t d;
    byte4_t c;
    set_mode(MODE_DECODE);
    send_group(32'h0000_0000, calc_checks(32'h0000_0000));
    send_group(32'hffff_ffff, calc_checks(32'hffff_ffff));
    d = 32'h3c5a_96e1;
    for (int k = 0; k < 4; k++) begin
      c = calc_checks(d);
      c[k] = c[k] ^ 8'h80;
      send_group(d, c);
    end
    for (int k = 0; k < 4; k++) begin
      byte4_t bad;
      bad = d;
      bad[k] = bad[k] ^ (k == 0 ? 8'hff : 8'h01 << k);
      send_group(bad, calc_checks(d));
    end
    c = calc_checks(d);
    c[0] = ~c[0];
    c[1] = ~c[1];
    send_group(d, c);
    send_group(d, ~calc_checks(d));
    send_group(32'hffff_ffff, 32'h0000_0000);
  endtask

  task automatic test_encode_random();
    set_mode(MODE_ENCODE);
    repeat (250) send_group($urandom, $urandom);
  endtask

  task automatic test_decode_random();
    set_mode(MODE_DECODE);
    repeat (750) send_random_decode();
  endtask

  task automatic test_back_to_back();
    set_mode(MODE_DECODE);
    idle_on = 1'b0;
    repeat (100) send_random_decode();
    set_mode(MODE_ENCODE);
    repeat (50) send_group($urandom, $urandom);
    wait_drained();
    idle_on = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    drv_data = '0;
    drv_check = '0;
    mode_q = MODE_ENCODE;
    fixed_cnt = '0;
    lost_cnt = '0;
    failed = 1'b0;
    idle_on = 1'b1;
    out_hold = 0;
    cycle_cnt = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_encode_corners();
    test_decode_corners();
    test_encode_random();
    test_decode_random();
    test_back_to_back();
    wait_drained();
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
